/* sv/ect_pkg.sv */
// Shared types and constants for the ear clipping triangulator.
`default_nettype none
package ect_pkg;

    localparam int AREA_BITS = 34;
    localparam logic [AREA_BITS-1:0] AREA_MAX = '1;

    localparam logic KIND_TRI = 1'b0;
    localparam logic KIND_SUM = 1'b1;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_START,
        ST_SCAN,
        ST_SEEK_A,
        ST_SEEK_B,
        ST_FETCH,
        ST_FACE_ISSUE,
        ST_FACE_WAIT,
        ST_FACE_EVAL,
        ST_INNER,
        ST_INNER_EVAL,
        ST_TRI_OUT,
        ST_ROUND_END,
        ST_SUMMARY
    } state_t;

endpackage
`default_nettype wire

/* sv/ect_ifs.sv */
// Valid/ready channel interfaces for vertex words and result words.
`default_nettype none
interface ect_vtx_if #(
    parameter int COORD_BITS = 16,
    parameter int ID_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] x_coord;
    logic signed [COORD_BITS-1:0] y_coord;
    logic [ID_BITS-1:0]           vertex_id;
    logic                         last_vertex;

    modport source (output valid, x_coord, y_coord, vertex_id, last_vertex, input ready);
    modport sink (input valid, x_coord, y_coord, vertex_id, last_vertex, output ready);
endinterface

interface ect_res_if #(
    parameter int ID_BITS = 16
);
    logic               valid;
    logic               ready;
    logic               item_kind;
    logic [ID_BITS-1:0] corner_a;
    logic [ID_BITS-1:0] apex;
    logic [ID_BITS-1:0] corner_b;
    logic [33:0]        doubled_area;
    logic               last_result;

    modport source (output valid, item_kind, corner_a, apex, corner_b, doubled_area,
                    last_result, input ready);
    modport sink (input valid, item_kind, corner_a, apex, corner_b, doubled_area,
                  last_result, output ready);
endinterface
`default_nettype wire

/* sv/ect_cross.sv */
// Two-stage pipelined cross product (q - p) x (r - p).
`default_nettype none
module ect_cross #(
    parameter int W = 17
) (
    input  wire logic                  clk,
    input  wire logic signed [W-1:0]   px,
    input  wire logic signed [W-1:0]   py,
    input  wire logic signed [W-1:0]   qx,
    input  wire logic signed [W-1:0]   qy,
    input  wire logic signed [W-1:0]   rx,
    input  wire logic signed [W-1:0]   ry,
    output logic signed [2*W+2:0]      res
);
    logic signed [W:0]     ux, uy, vx, vy;
    logic signed [2*W+1:0] p1_reg, p2_reg;
    logic signed [2*W+2:0] res_reg;

    assign ux = {qx[W-1], qx} - {px[W-1], px};
    assign uy = {qy[W-1], qy} - {py[W-1], py};
    assign vx = {rx[W-1], rx} - {px[W-1], px};
    assign vy = {ry[W-1], ry} - {py[W-1], py};

    always_ff @(posedge clk)
    begin
        p1_reg  <= ux * vy;
        p2_reg  <= uy * vx;
        res_reg <= {p1_reg[2*W+1], p1_reg} - {p2_reg[2*W+1], p2_reg};
    end

    assign res = res_reg;
endmodule
`default_nettype wire

/* sv/ect_core.sv */
// Vertex memory, removal flags and the clipping sequencer.
`default_nettype none
module ect_core import ect_pkg::*; #(
    parameter int MAX_VERTS = 64,
    parameter int COORD_BITS = 16,
    parameter int ID_BITS = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         winding,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic signed [COORD_BITS-1:0] in_x,
    input  wire logic signed [COORD_BITS-1:0] in_y,
    input  wire logic [ID_BITS-1:0]           in_id,
    input  wire logic                         in_last,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic                              out_kind,
    output logic [ID_BITS-1:0]                out_a,
    output logic [ID_BITS-1:0]                out_apex,
    output logic [ID_BITS-1:0]                out_b,
    output logic [AREA_BITS-1:0]              out_area,
    output logic                              out_last
);
    localparam int C = COORD_BITS;
    localparam int AW = (MAX_VERTS > 1) ? $clog2(MAX_VERTS) : 1;
    localparam int CNTW = $clog2(MAX_VERTS + 1);
    localparam int BW = $clog2(MAX_VERTS + 2);
    localparam int UW = C + 1;
    localparam int RW = 2 * UW + 3;
    localparam int KW = (((C + 34) > (2 * C + 6)) ? (C + 34) : (2 * C + 6)) + 1;
    localparam int MW = 2 * C + ID_BITS;
    localparam int SW = RW + AREA_BITS;
    localparam logic [CNTW-1:0] MAXC = CNTW'(MAX_VERTS);
    localparam logic [CNTW-1:0] THREE = CNTW'(3);

    logic [MW-1:0] mem [MAX_VERTS];
    logic [MW-1:0] rdata_reg;
    logic [AW-1:0] raddr;
    logic          mem_we;

    state_t state_reg, state_next;
    logic [CNTW-1:0] cnt_reg, cnt_next, ic_reg, ic_next, live_reg, live_next;
    logic [MAX_VERTS-1:0] rm_reg, rm_next;
    logic [AW-1:0] io_reg, io_next, ia_reg, ia_next, ib_reg, ib_next, cur_reg, cur_next;
    logic va_reg, va_next, vb_reg, vc_reg;
    logic ska_reg, ska_next, skb_reg, skc_reg;
    logic [AW-1:0] ta_reg, ta_next, tb_reg, tc_reg;
    logic signed [UW-1:0] sb_reg, sc_reg;
    logic signed [KW-1:0] best_reg, best_next;
    logic best_ok_reg, best_ok_next;
    logic [BW-1:0] bf_reg, bf_next, lap_reg, lap_next;
    logic blk_reg, blk_next;
    logic signed [C-1:0] ox_reg, oy_reg, ax_reg, ay_reg, bx_reg, by_reg;
    logic [ID_BITS-1:0] oid_reg, aid_reg, bid_reg;
    logic [1:0] fph_reg, fph_next;
    logic signed [RW-1:0] c_reg, c_next;
    logic [AREA_BITS-1:0] sum_reg, sum_next;
    logic ov_reg, ov_next, ok_reg, ol_reg;
    logic [ID_BITS-1:0] oa_reg, oo_reg, ob_reg;
    logic [AREA_BITS-1:0] oar_reg;
    logic load_tri, load_sum;

    logic signed [C-1:0] rd_x, rd_y;
    logic [ID_BITS-1:0] rd_id;
    logic signed [UW-1:0] u0px, u0py, u0qx, u0qy, u0rx, u0ry;
    logic signed [UW-1:0] u1px, u1py, u1qx, u1qy, u1rx, u1ry;
    logic signed [UW-1:0] u2px, u2py, u2qx, u2qy, u2rx, u2ry;
    logic signed [UW-1:0] pxe, pye, oxe, oye, axe, aye, bxe, bye;
    logic signed [RW-1:0] s1, s2, s3, cneg;
    logic signed [KW-1:0] key;
    logic [AW-1:0] nm1, cand_dec, cand_inc, issue_idx;
    logic issuing, drained, space, face_back, covered, fwd;
    logic p1, p2, p3, n1, n2, n3, z1, z2, z3;
    logic [BW-1:0] bf_inc, lap_inc, n_ext;
    logic [SW-1:0] c_ext;
    logic [AREA_BITS-1:0] a2;
    logic [AREA_BITS:0] sum_wide;

    assign rd_x  = rdata_reg[C-1:0];
    assign rd_y  = rdata_reg[2*C-1:C];
    assign rd_id = rdata_reg[MW-1:2*C];
    assign fwd   = ~winding;

    assign pxe = {rd_x[C-1], rd_x};
    assign pye = {rd_y[C-1], rd_y};
    assign oxe = {ox_reg[C-1], ox_reg};
    assign oye = {oy_reg[C-1], oy_reg};
    assign axe = {ax_reg[C-1], ax_reg};
    assign aye = {ay_reg[C-1], ay_reg};
    assign bxe = {bx_reg[C-1], bx_reg};
    assign bye = {by_reg[C-1], by_reg};

    always_comb
    begin
        u0px = axe; u0py = aye; u0qx = oxe; u0qy = oye; u0rx = pxe; u0ry = pye;
        if (state_reg == ST_SCAN)
        begin
            u0px = '0; u0py = '0; u0qx = pxe; u0qy = -pye; u0rx = pye; u0ry = pxe;
        end
        else if (state_reg == ST_FACE_ISSUE)
        begin
            u0px = oxe; u0py = oye; u0qx = axe; u0qy = aye; u0rx = bxe; u0ry = bye;
        end
        u1px = oxe; u1py = oye; u1qx = bxe; u1qy = bye; u1rx = pxe; u1ry = pye;
        u2px = bxe; u2py = bye; u2qx = axe; u2qy = aye; u2rx = pxe; u2ry = pye;
    end

    ect_cross #(.W(UW)) u_cross0 (
        .clk(clk), .px(u0px), .py(u0py), .qx(u0qx), .qy(u0qy), .rx(u0rx), .ry(u0ry),
        .res(s1)
    );
    ect_cross #(.W(UW)) u_cross1 (
        .clk(clk), .px(u1px), .py(u1py), .qx(u1qx), .qy(u1qy), .rx(u1rx), .ry(u1ry),
        .res(s2)
    );
    ect_cross #(.W(UW)) u_cross2 (
        .clk(clk), .px(u2px), .py(u2py), .qx(u2qx), .qy(u2qy), .rx(u2rx), .ry(u2ry),
        .res(s3)
    );

    assign nm1      = AW'(cnt_reg - CNTW'(1));
    assign cand_dec = (cur_reg == '0) ? nm1 : cur_reg - AW'(1);
    assign cand_inc = (cur_reg == nm1) ? '0 : cur_reg + AW'(1);
    assign issue_idx = ic_reg[AW-1:0];
    assign issuing  = (ic_reg < cnt_reg);
    assign drained  = !issuing && !va_reg && !vb_reg && !vc_reg;
    assign space    = !ov_reg || out_ready;
    assign cneg     = winding ? -s1 : s1;
    assign face_back = cneg[RW-1];
    assign n_ext    = BW'(cnt_reg);
    assign bf_inc   = bf_reg + BW'(1);
    assign lap_inc  = lap_reg + BW'(1);
    assign key      = (KW'(sc_reg) <<< 32) + KW'(s1);

    assign z1 = (s1 == '0); assign n1 = s1[RW-1]; assign p1 = !z1 && !n1;
    assign z2 = (s2 == '0); assign n2 = s2[RW-1]; assign p2 = !z2 && !n2;
    assign z3 = (s3 == '0); assign n3 = s3[RW-1]; assign p3 = !z3 && !n3;
    assign covered = (p1 && p2 && p3) || (n1 && n2 && n3)
                  || (z1 && ((p2 && p3) || (n2 && n3)))
                  || (z2 && ((p3 && p1) || (n3 && n1)))
                  || (z3 && ((p1 && p2) || (n1 && n2)));

    assign c_ext    = {{AREA_BITS{1'b0}}, c_reg};
    assign a2       = (c_ext > SW'(AREA_MAX)) ? AREA_MAX : c_ext[AREA_BITS-1:0];
    assign sum_wide = {1'b0, sum_reg} + {1'b0, a2};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:       if (in_valid && in_last) state_next = ST_START;
            ST_START:      state_next = (cnt_reg < THREE) ? ST_SUMMARY : ST_SCAN;
            ST_SCAN:       if (drained) state_next = ST_SEEK_A;
            ST_SEEK_A:     if (!rm_reg[cand_dec]) state_next = ST_SEEK_B;
            ST_SEEK_B:     if (!rm_reg[cand_inc]) state_next = ST_FETCH;
            ST_FETCH:      if (fph_reg == 2'd3) state_next = ST_FACE_ISSUE;
            ST_FACE_ISSUE: state_next = ST_FACE_WAIT;
            ST_FACE_WAIT:  state_next = ST_FACE_EVAL;
            ST_FACE_EVAL:
            begin
                if (!face_back) state_next = ST_INNER;
                else if (bf_inc > n_ext) state_next = ST_ROUND_END;
                else state_next = ST_SEEK_A;
            end
            ST_INNER:      if (drained) state_next = ST_INNER_EVAL;
            ST_INNER_EVAL:
            begin
                if (!blk_reg) state_next = ST_TRI_OUT;
                else if (lap_inc > n_ext) state_next = ST_ROUND_END;
                else state_next = ST_SEEK_A;
            end
            ST_TRI_OUT:    if (space) state_next = ST_ROUND_END;
            ST_ROUND_END:  state_next = (live_reg > THREE) ? ST_SCAN : ST_SUMMARY;
            ST_SUMMARY:    if (space) state_next = ST_LOAD;
            default:       state_next = ST_LOAD;
        endcase
    end

    always_comb
    begin
        in_ready = (state_reg == ST_LOAD);
        mem_we = 1'b0;
        raddr = issue_idx;
        cnt_next = cnt_reg; ic_next = ic_reg; live_next = live_reg; rm_next = rm_reg;
        io_next = io_reg; ia_next = ia_reg; ib_next = ib_reg; cur_next = cur_reg;
        va_next = 1'b0; ska_next = 1'b0; ta_next = issue_idx;
        best_next = best_reg; best_ok_next = best_ok_reg;
        bf_next = bf_reg; lap_next = lap_reg; blk_next = blk_reg;
        fph_next = fph_reg; c_next = c_reg; sum_next = sum_reg;
        load_tri = 1'b0; load_sum = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_valid && cnt_reg < MAXC)
                begin
                    mem_we = 1'b1;
                    cnt_next = cnt_reg + CNTW'(1);
                end
            end
            ST_START, ST_ROUND_END:
            begin
                ic_next = '0; live_next = '0; best_ok_next = 1'b0;
                sum_next = (state_reg == ST_START) ? '0 : sum_reg;
            end
            ST_SCAN:
            begin
                va_next = issuing;
                ska_next = rm_reg[issue_idx];
                if (issuing) ic_next = ic_reg + CNTW'(1);
                if (vc_reg && !skc_reg)
                begin
                    live_next = live_reg + CNTW'(1);
                    if (!best_ok_reg || key > best_reg)
                    begin
                        best_next = key; best_ok_next = 1'b1; io_next = tc_reg;
                    end
                end
                if (drained)
                begin
                    cur_next = io_reg; bf_next = '0; lap_next = '0;
                end
            end
            ST_SEEK_A:
            begin
                if (!rm_reg[cand_dec])
                begin
                    ia_next = cand_dec; cur_next = io_reg;
                end
                else cur_next = cand_dec;
            end
            ST_SEEK_B:
            begin
                fph_next = '0;
                if (!rm_reg[cand_inc]) ib_next = cand_inc;
                else cur_next = cand_inc;
            end
            ST_FETCH:
            begin
                unique case (fph_reg)
                    2'd0: raddr = io_reg;
                    2'd1: raddr = ia_reg;
                    default: raddr = ib_reg;
                endcase
                fph_next = fph_reg + 2'd1;
            end
            ST_FACE_ISSUE, ST_FACE_WAIT: ;
            ST_FACE_EVAL:
            begin
                c_next = cneg;
                ic_next = '0; blk_next = 1'b0;
                if (face_back)
                begin
                    bf_next = bf_inc; lap_next = '0;
                    if (bf_inc > n_ext) rm_next[io_reg] = 1'b1;
                    else
                    begin
                        io_next = fwd ? ib_reg : ia_reg;
                        cur_next = fwd ? ib_reg : ia_reg;
                    end
                end
            end
            ST_INNER:
            begin
                va_next = issuing;
                ska_next = rm_reg[issue_idx] || issue_idx == ia_reg
                        || issue_idx == io_reg || issue_idx == ib_reg;
                if (issuing) ic_next = ic_reg + CNTW'(1);
                if (vc_reg && !skc_reg && covered) blk_next = 1'b1;
            end
            ST_INNER_EVAL:
            begin
                if (blk_reg)
                begin
                    lap_next = lap_inc;
                    if (lap_inc > n_ext) rm_next[io_reg] = 1'b1;
                    else
                    begin
                        io_next = fwd ? ib_reg : ia_reg;
                        cur_next = fwd ? ib_reg : ia_reg;
                    end
                end
            end
            ST_TRI_OUT:
            begin
                if (space)
                begin
                    load_tri = 1'b1;
                    sum_next = sum_wide[AREA_BITS] ? AREA_MAX : sum_wide[AREA_BITS-1:0];
                    rm_next[io_reg] = 1'b1;
                end
            end
            ST_SUMMARY:
            begin
                if (space)
                begin
                    load_sum = 1'b1;
                    rm_next = '0; cnt_next = '0; sum_next = '0;
                end
            end
            default: ;
        endcase
        ov_next = (load_tri || load_sum) ? 1'b1 : (out_ready ? 1'b0 : ov_reg);
    end

    always_ff @(posedge clk)
    begin
        if (mem_we) mem[cnt_reg[AW-1:0]] <= {in_id, in_y, in_x};
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            cnt_reg <= '0; ic_reg <= '0; live_reg <= '0; rm_reg <= '0;
            va_reg <= 1'b0; vb_reg <= 1'b0; vc_reg <= 1'b0;
            best_ok_reg <= 1'b0; bf_reg <= '0; lap_reg <= '0; blk_reg <= 1'b0;
            fph_reg <= '0; sum_reg <= '0; ov_reg <= 1'b0;
            io_reg <= '0; ia_reg <= '0; ib_reg <= '0; cur_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next; ic_reg <= ic_next; live_reg <= live_next; rm_reg <= rm_next;
            va_reg <= va_next; vb_reg <= va_reg; vc_reg <= vb_reg;
            best_ok_reg <= best_ok_next; bf_reg <= bf_next; lap_reg <= lap_next;
            blk_reg <= blk_next; fph_reg <= fph_next; sum_reg <= sum_next; ov_reg <= ov_next;
            io_reg <= io_next; ia_reg <= ia_next; ib_reg <= ib_next; cur_reg <= cur_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ska_reg <= ska_next; skb_reg <= ska_reg; skc_reg <= skb_reg;
        ta_reg <= ta_next; tb_reg <= ta_reg; tc_reg <= tb_reg;
        sb_reg <= pxe + pye; sc_reg <= sb_reg;
        best_reg <= best_next;
        c_reg <= c_next;
        if (state_reg == ST_FETCH && fph_reg == 2'd1)
        begin
            ox_reg <= rd_x; oy_reg <= rd_y; oid_reg <= rd_id;
        end
        if (state_reg == ST_FETCH && fph_reg == 2'd2)
        begin
            ax_reg <= rd_x; ay_reg <= rd_y; aid_reg <= rd_id;
        end
        if (state_reg == ST_FETCH && fph_reg == 2'd3)
        begin
            bx_reg <= rd_x; by_reg <= rd_y; bid_reg <= rd_id;
        end
        if (load_tri)
        begin
            ok_reg <= KIND_TRI; oa_reg <= aid_reg; oo_reg <= oid_reg; ob_reg <= bid_reg;
            oar_reg <= a2; ol_reg <= 1'b0;
        end
        else if (load_sum)
        begin
            ok_reg <= KIND_SUM; oa_reg <= '0; oo_reg <= '0; ob_reg <= '0;
            oar_reg <= sum_reg; ol_reg <= 1'b1;
        end
    end

    assign out_valid = ov_reg;
    assign out_kind  = ok_reg;
    assign out_a     = oa_reg;
    assign out_apex  = oo_reg;
    assign out_b     = ob_reg;
    assign out_area  = oar_reg;
    assign out_last  = ol_reg;
endmodule
`default_nettype wire

/* sv/ear_clipping_triangulator.sv */
// Top level of the ear clipping triangulator with the winding register.
// Vertices load at one word per cycle; the word marking the last vertex starts clipping.
// Each round runs an extreme-vertex scan over the vertex memory (largest x + y, ties to the
// larger x*x + y*y), then per walk step a neighbor search, a fetch and face test,
// and an inner-point test, all limited by the single memory read port.
// Reset clears the sequencer, the removal flags, the counters and the winding register.
`default_nettype none
module ear_clipping_triangulator import ect_pkg::*; #(
    parameter int MAX_VERTS = 64,
    parameter int COORD_BITS = 16,
    parameter int ID_BITS = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    ect_vtx_if.sink   vtx,
    ect_res_if.source res,
    input  wire logic cfg_we,
    input  wire logic cfg_wdata
);
    logic winding_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            winding_reg <= 1'b0;
        else if (cfg_we)
            winding_reg <= cfg_wdata;
    end

    ect_core #(
        .MAX_VERTS(MAX_VERTS),
        .COORD_BITS(COORD_BITS),
        .ID_BITS(ID_BITS)
    ) u_core (
        .clk(clk),
        .rst_n(rst_n),
        .winding(winding_reg),
        .in_valid(vtx.valid),
        .in_ready(vtx.ready),
        .in_x(vtx.x_coord),
        .in_y(vtx.y_coord),
        .in_id(vtx.vertex_id),
        .in_last(vtx.last_vertex),
        .out_valid(res.valid),
        .out_ready(res.ready),
        .out_kind(res.item_kind),
        .out_a(res.corner_a),
        .out_apex(res.apex),
        .out_b(res.corner_b),
        .out_area(res.doubled_area),
        .out_last(res.last_result)
    );
endmodule
`default_nettype wire

/* sv/ect_chk.sv */
// Port-level checker for the ear clipping triangulator and its bind.
`default_nettype none
module ect_chk #(
    parameter int ID_BITS = 16
) (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               vtx_ready,
    input wire logic               res_valid,
    input wire logic               res_ready,
    input wire logic               item_kind,
    input wire logic [ID_BITS-1:0] corner_a,
    input wire logic [ID_BITS-1:0] apex,
    input wire logic [ID_BITS-1:0] corner_b,
    input wire logic               last_result
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result word dropped while stalled");

    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> item_kind == last_result)
        else $error("summary kind and last flag disagree");

    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && item_kind |-> corner_a == '0 && apex == '0 && corner_b == '0)
        else $error("summary word carries vertex ids");

    a_run: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !last_result |-> !vtx_ready)
        else $error("vertex input open while a triangle is pending");
endmodule

bind ear_clipping_triangulator ect_chk #(.ID_BITS(ID_BITS)) u_ect_chk (
    .clk(clk),
    .rst_n(rst_n),
    .vtx_ready(vtx.ready),
    .res_valid(res.valid),
    .res_ready(res.ready),
    .item_kind(res.item_kind),
    .corner_a(res.corner_a),
    .apex(res.apex),
    .corner_b(res.corner_b),
    .last_result(res.last_result)
);
`default_nettype wire
